// ===== rtl/aad_pkg.sv =====
// ----------------------------------------------------------------------------
// aad_pkg: shared types and constants of the angular alternation depth block
// Holds the sequencer state type and the fixed widths of the order register.
// ----------------------------------------------------------------------------
package aad_pkg;

	// width and reset value of the order register
	localparam int unsigned ORDER_W     = 4;
	localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd3;

	// sequencer states, one-hot
	typedef enum logic [7:0] {
		S_LOAD = 8'b0000_0001,
		S_RDC  = 8'b0000_0010,
		S_WC   = 8'b0000_0100,
		S_RDA  = 8'b0000_1000,
		S_WA   = 8'b0001_0000,
		S_RANK = 8'b0010_0000,
		S_CNT  = 8'b0100_0000,
		S_SUM  = 8'b1000_0000
	} aad_state_t;

endpackage

// ===== rtl/angular_alternation_depth.sv =====
// ----------------------------------------------------------------------------
// angular_alternation_depth: alternating sign subsequence depth of point sets
// Loads planar points, orders the others by slope around each point and
// counts alternating sign subsequences of the ordered x-differences.
// ----------------------------------------------------------------------------
// Points are taken one word per cycle; the word with tlast closes the set and
// the block then stops taking words until one result per stored point has
// been delivered, in load order. In the compute phase each point pair ranks
// itself against every stored point through the single read port of the
// coordinate memories, one point per cycle behind a three-stage
// subtract/multiply/compare pipe, and the counter table then steps through
// the n-1 ordered signs one per cycle.
// Points beyond MAX_POINTS are dropped. order_k above MAX_ORDER acts as
// MAX_ORDER; write cfg_we only while no set is being computed.
module angular_alternation_depth
	import aad_pkg::*;
#(
	parameter int MAX_POINTS  = 64,
	parameter int MAX_ORDER   = 8,
	parameter int COORD_WIDTH = 32,
	parameter int COUNT_WIDTH = 48
) (
	input  logic clk,
	input  logic arst_n,
	// configuration: order_k
	input  logic                cfg_we,
	input  logic [ORDER_W-1:0]  cfg_data,
	// point words
	input  logic                s_tvalid,
	output logic                s_tready,
	// s_tdata: point_x, point_y
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	input  logic                s_tlast,   // last_point
	// result words
	output logic                m_tvalid,
	input  logic                m_tready,
	// m_tdata: point_index, depth_count
	output logic [(($clog2(MAX_POINTS)+COUNT_WIDTH+7)/8)*8-1:0] m_tdata,
	output logic                m_tlast    // last_result
);

	localparam int IW   = $clog2(MAX_POINTS);
	localparam int NW   = $clog2(MAX_POINTS + 1);
	localparam int DW   = COORD_WIDTH + 1;
	localparam int PW   = 2 * DW;
	localparam int KW   = $clog2(MAX_ORDER + 1);
	localparam int OUTW = ((IW + COUNT_WIDTH + 7) / 8) * 8;
	localparam logic [NW-1:0] NMAX = NW'(MAX_POINTS);

	function automatic logic [COUNT_WIDTH-1:0] sat_add(
		input logic [COUNT_WIDTH-1:0] a,
		input logic [COUNT_WIDTH-1:0] b
	);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
	endfunction

	function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
		return v[DW-1] ? DW'(-v) : DW'(v);
	endfunction

	// memories
	logic [COORD_WIDTH-1:0] x_mem [0:MAX_POINTS-1];
	logic [COORD_WIDTH-1:0] y_mem [0:MAX_POINTS-1];
	logic                   ord_mem [0:MAX_POINTS-1];

	aad_state_t state_q;
	logic [ORDER_W-1:0] order_q;
	logic [NW-1:0] n_q, c_q, a_q, b_q, j_q;
	logic [IW-1:0] rank_q;
	logic [COORD_WIDTH-1:0] x_rd_q, y_rd_q, xc_q, yc_q;
	logic ord_rd_q;
	logic signed [DW-1:0] dxa_q, dya_q;
	logic cola_q;

	// rank pipeline
	logic v_s1, v_s2, v_s3;
	logic blt_s1, blt_s2, blt_s3;
	logic signed [DW-1:0] dxb_s2, dyb_s2;
	logic [PW-1:0] pa_s3, pb_s3;
	logic va_s3, vb_s3, na_s3, nb_s3;
	logic cv_s1;

	logic [COUNT_WIDTH-1:0] tab_q [0:MAX_ORDER][0:1];

	logic out_v_q, out_last_q;
	logic [IW-1:0] out_idx_q;
	logic [COUNT_WIDTH-1:0] out_cnt_q;

	logic [KW-1:0] k_eff;
	logic [IW-1:0] rd_addr;
	logic ld_acc, ord_we, pipe_busy, lt_ab, lt_ba, out_free, out_load;
	logic signed [DW-1:0] dxb_c, dyb_c, dxa_c, dya_c;

	assign k_eff    = (int'(order_q) > MAX_ORDER) ? KW'(MAX_ORDER) : KW'(order_q);
	assign s_tready = (state_q == S_LOAD);
	assign ld_acc   = s_tvalid && s_tready;
	assign pipe_busy = v_s1 || v_s2 || v_s3;
	assign ord_we   = (state_q == S_RANK) && (b_q == n_q) && !pipe_busy;
	assign out_free = !out_v_q || m_tready;
	assign out_load = (state_q == S_SUM) && out_free;

	// pick the coordinate read address
	always_comb begin
		unique case (state_q)
			S_RDC:   rd_addr = c_q[IW-1:0];
			S_RDA:   rd_addr = a_q[IW-1:0];
			default: rd_addr = b_q[IW-1:0];
		endcase
	end

	// coordinate and order memories
	always_ff @(posedge clk) begin
		if (ld_acc && n_q < NMAX) begin
			x_mem[n_q[IW-1:0]] <= s_tdata[COORD_WIDTH-1:0];
			y_mem[n_q[IW-1:0]] <= s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
		end
		x_rd_q <= x_mem[rd_addr];
		y_rd_q <= y_mem[rd_addr];
		if (ord_we) begin
			ord_mem[rank_q] <= cola_q;
		end
		ord_rd_q <= ord_mem[j_q[IW-1:0]];
	end

	// differences of the fetched point against the center
	assign dxb_c = DW'(signed'(x_rd_q)) - DW'(signed'(xc_q));
	assign dyb_c = DW'(signed'(y_rd_q)) - DW'(signed'(yc_q));
	assign dxa_c = dxb_c;
	assign dya_c = dyb_c;

	// slope order of a and b around the center
	always_comb begin
		if (va_s3) begin
			lt_ab = 1'b0;
		end else if (vb_s3) begin
			lt_ab = 1'b1;
		end else if (na_s3 != nb_s3) begin
			lt_ab = na_s3;
		end else begin
			lt_ab = na_s3 ? (pa_s3 > pb_s3) : (pa_s3 < pb_s3);
		end
		if (vb_s3) begin
			lt_ba = 1'b0;
		end else if (va_s3) begin
			lt_ba = 1'b1;
		end else if (na_s3 != nb_s3) begin
			lt_ba = nb_s3;
		end else begin
			lt_ba = nb_s3 ? (pb_s3 > pa_s3) : (pb_s3 < pa_s3);
		end
	end

	// rank pipeline payload
	always_ff @(posedge clk) begin
		dxb_s2 <= dxb_c;
		dyb_s2 <= dyb_c;
		blt_s2 <= blt_s1;
		pa_s3  <= PW'(mag(dya_q)) * PW'(mag(dxb_s2));
		pb_s3  <= PW'(mag(dyb_s2)) * PW'(mag(dxa_q));
		va_s3  <= (dxa_q == '0);
		vb_s3  <= (dxb_s2 == '0);
		na_s3  <= (dya_q != '0) && (dya_q[DW-1] != dxa_q[DW-1]);
		nb_s3  <= (dyb_s2 != '0) && (dyb_s2[DW-1] != dxb_s2[DW-1]);
		blt_s3 <= blt_s2;
	end

	// sequencer, loop counters and counter table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			order_q <= ORDER_RESET;
			n_q <= '0; c_q <= '0; a_q <= '0; b_q <= '0; j_q <= '0;
			rank_q <= '0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; cv_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				order_q <= cfg_data;
			end
			// load a result word or drop the taken one
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			// issue one b point per rank cycle, one sign per count cycle
			v_s1  <= (state_q == S_RANK) && (b_q != n_q) && (b_q != c_q) && (b_q != a_q);
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			cv_s1 <= (state_q == S_CNT) && (j_q != n_q - 1'b1);
			// count b points that sort ahead of a
			if (v_s3 && (lt_ba || (blt_s3 && !lt_ab))) begin
				rank_q <= rank_q + 1'b1;
			end
			// advance the counter table by one sign
			if (cv_s1) begin
				for (int r = 1; r <= MAX_ORDER; r++) begin
					tab_q[r][ord_rd_q] <= sat_add(tab_q[r][ord_rd_q],
						tab_q[r-1][!ord_rd_q]);
				end
			end
			unique case (state_q)
				S_LOAD: begin
					if (ld_acc) begin
						if (n_q < NMAX) begin
							n_q <= n_q + 1'b1;
						end
						if (s_tlast) begin
							c_q <= '0;
							state_q <= S_RDC;
						end
					end
				end
				S_RDC: state_q <= S_WC;
				S_WC: begin
					xc_q <= x_rd_q;
					yc_q <= y_rd_q;
					for (int r = 0; r <= MAX_ORDER; r++) begin
						tab_q[r][0] <= (r == 0) ? COUNT_WIDTH'(1) : '0;
						tab_q[r][1] <= (r == 0) ? COUNT_WIDTH'(1) : '0;
					end
					a_q <= '0;
					state_q <= S_RDA;
				end
				S_RDA: begin
					if (a_q == n_q) begin
						j_q <= '0;
						state_q <= S_CNT;
					end else if (a_q == c_q) begin
						a_q <= a_q + 1'b1;
					end else begin
						state_q <= S_WA;
					end
				end
				S_WA: begin
					dxa_q  <= dxa_c;
					dya_q  <= dya_c;
					cola_q <= !dxa_c[DW-1];
					b_q    <= '0;
					rank_q <= '0;
					state_q <= S_RANK;
				end
				S_RANK: begin
					if (b_q != n_q) begin
						blt_s1 <= (b_q < a_q);
						b_q    <= b_q + 1'b1;
					end else if (!pipe_busy) begin
						a_q <= a_q + 1'b1;
						state_q <= S_RDA;
					end
				end
				S_CNT: begin
					if (j_q != n_q - 1'b1) begin
						j_q   <= j_q + 1'b1;
					end else if (!cv_s1) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					if (out_load) begin
						out_idx_q  <= c_q[IW-1:0];
						out_cnt_q  <= sat_add(tab_q[k_eff][0], tab_q[k_eff][1]);
						out_last_q <= (c_q + 1'b1 == n_q);
						if (c_q + 1'b1 == n_q) begin
							n_q <= '0;
							state_q <= S_LOAD;
						end else begin
							c_q <= c_q + 1'b1;
							state_q <= S_RDC;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = OUTW'({out_cnt_q, out_idx_q});

	// rank never outruns the points issued so far
	a_rank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RANK) |-> (NW'(rank_q) <= b_q))
		else $error("rank above issued count");

	// an order entry is written only inside the set
	a_ord_write: assert property (@(posedge clk) disable iff (!arst_n)
		ord_we |-> (NW'(rank_q) < n_q))
		else $error("order write beyond set");

	// no rank work in flight while taking points
	a_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!pipe_busy && !cv_s1))
		else $error("pipeline busy while loading");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for angular_alternation_depth
// Streams point sets into the block, predicts each per-point alternation
// count with an in-bench slope sort and counter table, and checks every
// result word against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_top
	import aad_pkg::*;
();

	localparam int NPTS      = 64;
	localparam int ORDER_MAX = 8;
	localparam int CW        = 48;
	localparam longint unsigned CNT_SAT = (64'd1 << CW) - 1;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int HOLD_CYCLES = 1500;

	typedef struct {
		logic [5:0]    idx;
		logic [CW-1:0] cnt;
		logic          last;
	} depth_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [ORDER_W-1:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// s_tdata: point_x [31:0], point_y [63:32]
	logic [63:0] s_tdata = '0;
	logic        s_tlast = 1'b0;    // last_point
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// m_tdata: point_index [5:0], depth_count [53:6], zero fill [55:54]
	logic [55:0] m_tdata;
	logic        m_tlast;           // last_result

	// predictor state
	longint      x_mem [NPTS];
	longint      y_mem [NPTS];
	int          n_stored = 0;
	int          order_reg = ORDER_RESET;
	depth_word_t depth_q [$];

	int src_idle = 0;
	int snk_idle = 0;
	int mismatches = 0;
	int cycles = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;

	angular_alternation_depth dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #6 clk = ~clk;

	// abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// long receiver hold, counted here
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// drive ready and check each result word
	always @(posedge clk) begin
		depth_word_t want;
		m_tready <= arst_n && (hold_left == 0) && ($urandom_range(99) >= snk_idle);
		if (m_tvalid && m_tready) begin
			if (depth_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word idx=%0d cnt=%0d", m_tdata[5:0], m_tdata[53:6]);
			end else begin
				want = depth_q.pop_front();
				if (m_tdata[5:0] !== want.idx || m_tdata[53:6] !== want.cnt
				    || m_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp idx=%0d cnt=%0d last=%0b got idx=%0d cnt=%0d last=%0b",
						         want.idx, want.cnt, want.last,
						         m_tdata[5:0], m_tdata[53:6], m_tlast);
				end
			end
		end
	end

	// true if slope from c to a is strictly below slope from c to b
	function automatic bit slope_below(int c, int a, int b);
		longint dxa, dya, dxb, dyb;
		longint unsigned pa, pb, ma_x, ma_y, mb_x, mb_y;
		bit na, nb;
		dxa = x_mem[a] - x_mem[c];
		dya = y_mem[a] - y_mem[c];
		dxb = x_mem[b] - x_mem[c];
		dyb = y_mem[b] - y_mem[c];
		if (dxa == 0) return 1'b0;
		if (dxb == 0) return 1'b1;
		ma_x = (dxa < 0) ? -dxa : dxa;
		ma_y = (dya < 0) ? -dya : dya;
		mb_x = (dxb < 0) ? -dxb : dxb;
		mb_y = (dyb < 0) ? -dyb : dyb;
		pa = ma_y * mb_x;
		pb = mb_y * ma_x;
		na = (pa != 0) && ((dya < 0) != (dxa < 0));
		nb = (pb != 0) && ((dyb < 0) != (dxb < 0));
		if (na != nb) return na;
		return na ? (pa > pb) : (pa < pb);
	endfunction

	function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
		longint unsigned s;
		s = a + b;
		return (s > CNT_SAT) ? CNT_SAT : s;
	endfunction

	// sort the others by slope around c, then run the alternation table
	function automatic longint unsigned point_depth(int c, int n, int k);
		int ord [NPTS];
		longint unsigned tbl [ORDER_MAX+1][2];
		int cnt, j, col;
		cnt = 0;
		for (int a = 0; a < n; a++) begin
			if (a == c) continue;
			j = cnt;
			while (j > 0 && slope_below(c, a, ord[j-1])) begin
				ord[j] = ord[j-1];
				j--;
			end
			ord[j] = a;
			cnt++;
		end
		for (int r = 0; r <= ORDER_MAX; r++) begin
			tbl[r][0] = 0;
			tbl[r][1] = 0;
		end
		tbl[0][0] = 1;
		tbl[0][1] = 1;
		for (int p = 0; p < cnt; p++) begin
			col = (x_mem[ord[p]] - x_mem[c] < 0) ? 0 : 1;
			for (int r = 1; r <= k; r++)
				tbl[r][col] = sat_sum(tbl[r][col], tbl[r-1][1-col]);
		end
		return sat_sum(tbl[k][0], tbl[k][1]);
	endfunction

	// store an accepted point; on last, queue one count per stored point
	task automatic predict_point(logic [31:0] x, logic [31:0] y, bit last);
		depth_word_t w;
		int k;
		if (n_stored < NPTS) begin
			x_mem[n_stored] = longint'(signed'(x));
			y_mem[n_stored] = longint'(signed'(y));
			n_stored++;
		end
		if (!last) return;
		k = (order_reg > ORDER_MAX) ? ORDER_MAX : order_reg;
		for (int i = 0; i < n_stored; i++) begin
			w.idx = i[5:0];
			w.cnt = point_depth(i, n_stored, k);
			w.last = (i + 1 == n_stored);
			depth_q.push_back(w);
		end
		n_stored = 0;
	endtask

	// offer one point word until it is taken
	task automatic send_point(logic [31:0] x, logic [31:0] y, bit last);
		if ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {y, x};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		predict_point(x, y, last);
	endtask

	task automatic go_quiet();
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		go_quiet();
		while (depth_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// write order_k with the block idle
	task automatic write_order(int k);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= k[ORDER_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		order_reg = k;
		@(posedge clk);
	endtask

	// coordinate mix: full range, small grid for ties and verticals, extremes
	function automatic logic [31:0] pick_coord();
		case ($urandom_range(5))
			0, 1: return $urandom;
			2, 3: return ($urandom_range(8) - 4) << 16;
			4: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
			default: return $urandom_range(1) ? 32'h0 : 32'hffff_ffff;
		endcase
	endfunction

	task automatic send_set(int n);
		for (int i = 0; i < n; i++)
			send_point(pick_coord(), pick_coord(), i == n - 1);
	endtask

	task automatic test_directed();
		// single point at reset order, then at order zero
		send_point(32'h0001_0000, 32'h0002_0000, 1'b1);
		write_order(0);
		send_point(32'h8000_0000, 32'h7fff_ffff, 1'b1);
		send_set(3);
		// extremes, vertical and coincident pairs
		write_order(15);
		send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
		send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
		send_point(32'h0000_0000, 32'h7fff_ffff, 1'b0);
		send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
		send_point(32'h8000_0000, 32'h7fff_ffff, 1'b1);
		write_order(1);
		send_point(32'hffff_ffff, 32'h0000_0001, 1'b0);
		send_point(32'h0000_0001, 32'hffff_ffff, 1'b0);
		send_point(32'h5555_5555, 32'haaaa_aaaa, 1'b1);
		write_order(8);
		send_set(6);
		drain();
	endtask

	// fill the store, then one dropped point carrying last
	task automatic test_store_full();
		write_order(2);
		for (int i = 0; i <= NPTS; i++)
			send_point($urandom, $urandom, i == NPTS);
		drain();
	endtask

	task automatic test_backpressure();
		write_order(4);
		hold_req <= hold_req + 1;
		send_set(5);
		send_set(4);
		send_set(3);
		// hold sending until every count is in
		drain();
	endtask

	task automatic test_random(int items);
		int sent, n;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(3) == 0) write_order($urandom_range(15));
			n = ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
			send_set(n);
			sent += n;
		end
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_store_full();
		test_backpressure();
		src_idle = 34; snk_idle = 81;
		test_random(75);
		src_idle = 81; snk_idle = 34;
		test_random(75);
		src_idle = 0; snk_idle = 0;
		test_random(75);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && depth_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
